@@ hw/rtl/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher: item kinds, datapath
// operation codes and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int PermDepth = 256;
  localparam int PermAw    = 8;
  localparam int ByteW     = 8;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [PermAw-1:0] paddr_t;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_D_RD_I  = 4'd1;
  localparam op_t OP_D_RD_J  = 4'd2;
  localparam op_t OP_D_WR_I  = 4'd3;
  localparam op_t OP_D_WR_J  = 4'd4;
  localparam op_t OP_D_RD_K  = 4'd5;
  localparam op_t OP_D_OUT   = 4'd6;
  localparam op_t OP_K_OUT   = 4'd7;
  localparam op_t OP_S_START = 4'd8;
  localparam op_t OP_S_RD_C  = 4'd9;
  localparam op_t OP_S_RD_A  = 4'd10;
  localparam op_t OP_S_WR_C  = 4'd11;
  localparam op_t OP_S_WR_A  = 4'd12;
  localparam op_t OP_S_DONE  = 4'd13;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sch_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rc4_stream_cipher.sv @@
// Data byte: reads S[i+1] and S[j], swaps them, reads S[S[i]+S[j]] and registers
// the XOR result when the output is free; no new request is taken until then, as
// the serial reads and swap share the single permutation memory port. Key byte:
// result registered when the output is free. Last key byte: runs the key schedule.
// Synchronous active-low reset; the permutation reads as all zeros until the key schedule starts.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher with byte-serial key loading and keystream XOR.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
  parameter int KEY_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte_out,
  output logic            out_last_out,
  output logic            out_key_ready,
  output logic            out_key_overflow
);
  import rc4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_last  (in_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  rc4_dp #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_byte_in       (in_byte_in),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_out     (out_byte_out),
    .out_last_out     (out_last_out),
    .out_key_ready    (out_key_ready),
    .out_key_overflow (out_key_overflow)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rc4_ram.sv @@
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with a registered read port that
// updates only when a read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rc4_ctrl.sv @@
// ----------------------------------------------------------------------------
// rc4_ctrl
// Controller: accepts requests, sequences the keystream step and the key schedule,
// and issues one datapath operation per cycle unless idle or waiting for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire logic          in_last,
  input  wire rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t      cmd
);
  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_D_RD_I = 4'd1;
  localparam logic [3:0] ST_D_RD_J = 4'd2;
  localparam logic [3:0] ST_D_WR_I = 4'd3;
  localparam logic [3:0] ST_D_WR_J = 4'd4;
  localparam logic [3:0] ST_D_RD_K = 4'd5;
  localparam logic [3:0] ST_D_OUT  = 4'd6;
  localparam logic [3:0] ST_K_OUT  = 4'd7;
  localparam logic [3:0] ST_S_INIT = 4'd8;
  localparam logic [3:0] ST_S_RD_C = 4'd9;
  localparam logic [3:0] ST_S_RD_A = 4'd10;
  localparam logic [3:0] ST_S_WR_C = 4'd11;
  localparam logic [3:0] ST_S_WR_A = 4'd12;
  localparam logic [3:0] ST_S_DONE = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_kind == KIND_DATA) begin
            state_nxt = ST_D_RD_I;
          end else if (in_last) begin
            state_nxt = ST_S_INIT;
          end else begin
            state_nxt = ST_K_OUT;
          end
        end
      end
      ST_D_RD_I: begin
        cmd.op    = OP_D_RD_I;
        state_nxt = ST_D_RD_J;
      end
      ST_D_RD_J: begin
        cmd.op    = OP_D_RD_J;
        state_nxt = ST_D_WR_I;
      end
      ST_D_WR_I: begin
        cmd.op    = OP_D_WR_I;
        state_nxt = ST_D_WR_J;
      end
      ST_D_WR_J: begin
        cmd.op    = OP_D_WR_J;
        state_nxt = ST_D_RD_K;
      end
      ST_D_RD_K: begin
        cmd.op    = OP_D_RD_K;
        state_nxt = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_D_OUT;
          state_nxt = ST_IDLE;
        end
      end
      ST_K_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_K_OUT;
          state_nxt = ST_IDLE;
        end
      end
      ST_S_INIT: begin
        cmd.op    = OP_S_START;
        state_nxt = ST_S_RD_C;
      end
      ST_S_RD_C: begin
        cmd.op    = OP_S_RD_C;
        state_nxt = ST_S_RD_A;
      end
      ST_S_RD_A: begin
        cmd.op    = OP_S_RD_A;
        state_nxt = ST_S_WR_C;
      end
      ST_S_WR_C: begin
        cmd.op    = OP_S_WR_C;
        state_nxt = ST_S_WR_A;
      end
      ST_S_WR_A: begin
        cmd.op    = OP_S_WR_A;
        state_nxt = sts.sch_last ? ST_S_DONE : ST_S_RD_C;
      end
      ST_S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_S_DONE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rc4_dp.sv @@
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath: permutation and key memories, indices, schedule counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp #(
  parameter int KEY_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rc4_pkg::cmd_t cmd,
  output rc4_pkg::sts_t      sts,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_byte_in,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte_out,
  output logic               out_last_out,
  output logic               out_key_ready,
  output logic               out_key_overflow
);
  import rc4_pkg::*;

  localparam int KcW = $clog2(KEY_DEPTH + 1);
  localparam int KaW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // Permutation state and its read-side masking.
  logic [PermDepth-1:0] pvld_r;
  logic                 ident_r;
  logic                 pvld_q_r;
  paddr_t               paddr_q_r;
  logic                 pwe;
  paddr_t               pwaddr;
  byte_t                pwdata;
  logic                 pre;
  paddr_t               praddr;
  byte_t                prdata;
  byte_t                perm_rd;

  // Key store.
  logic                 kwe;
  logic [KaW-1:0]       kwaddr;
  logic [KaW-1:0]       k_r;
  logic [KaW-1:0]       kmax_r;
  logic [KcW-1:0]       key_count_r;
  logic [KcW-1:0]       kc_m1;
  logic                 key_full;
  logic                 kre;
  byte_t                krdata;

  // Indices and working registers.
  byte_t                i_r;
  byte_t                j_r;
  byte_t                si_r;
  byte_t                sj_r;
  byte_t                sc_r;
  byte_t                acc_r;
  paddr_t               c_r;
  logic                 keyed_r;
  byte_t                hold_byte_r;
  logic                 hold_last_r;
  logic                 ovf_r;
  logic                 out_load;

  logic                 out_valid_r;
  byte_t                out_byte_r;
  logic                 out_last_r;
  logic                 out_kr_r;
  logic                 out_ovf_r;

  assign key_full = (key_count_r == KcW'(KEY_DEPTH));
  assign kc_m1    = key_count_r - KcW'(1);
  assign kwe      = cmd.capture && (in_kind == KIND_KEY) && !key_full;
  assign kwaddr   = key_count_r[KaW-1:0];
  assign kre      = (cmd.op == OP_S_RD_C);
  assign perm_rd  = pvld_q_r ? prdata : (ident_r ? paddr_q_r : '0);
  assign out_load = (cmd.op == OP_D_OUT) || (cmd.op == OP_K_OUT) || (cmd.op == OP_S_DONE);

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.sch_last = (c_r == paddr_t'(PermDepth - 1));

  always_comb begin
    pre    = 1'b0;
    praddr = '0;
    pwe    = 1'b0;
    pwaddr = '0;
    pwdata = '0;
    case (cmd.op)
      OP_D_RD_I: begin
        pre    = 1'b1;
        praddr = i_r + 8'd1;
      end
      OP_D_RD_J: begin
        pre    = 1'b1;
        praddr = j_r + perm_rd;
      end
      OP_D_WR_I: begin
        pwe    = 1'b1;
        pwaddr = i_r;
        pwdata = perm_rd;
      end
      OP_D_WR_J: begin
        pwe    = 1'b1;
        pwaddr = j_r;
        pwdata = si_r;
      end
      OP_D_RD_K: begin
        pre    = 1'b1;
        praddr = si_r + sj_r;
      end
      OP_S_RD_C: begin
        pre    = 1'b1;
        praddr = c_r;
      end
      OP_S_RD_A: begin
        pre    = 1'b1;
        praddr = acc_r + krdata + perm_rd;
      end
      OP_S_WR_C: begin
        pwe    = 1'b1;
        pwaddr = c_r;
        pwdata = perm_rd;
      end
      OP_S_WR_A: begin
        pwe    = 1'b1;
        pwaddr = acc_r;
        pwdata = sc_r;
      end
      default: begin
        pre = 1'b0;
      end
    endcase
  end

  rc4_ram #(
    .WIDTH (ByteW),
    .DEPTH (PermDepth)
  ) u_perm_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata),
    .re    (pre),
    .raddr (praddr),
    .rdata (prdata)
  );

  rc4_ram #(
    .WIDTH (ByteW),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (in_byte_in),
    .re    (kre),
    .raddr (k_r),
    .rdata (krdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r      <= '0;
      ident_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pwe) begin
        pvld_r[pwaddr] <= 1'b1;
      end
      if (kwe) begin
        key_count_r <= key_count_r + KcW'(1);
      end
      case (cmd.op)
        OP_D_RD_I: begin
          i_r <= i_r + 8'd1;
        end
        OP_D_RD_J: begin
          j_r <= j_r + perm_rd;
        end
        OP_S_START: begin
          pvld_r  <= '0;
          ident_r <= 1'b1;
        end
        OP_S_DONE: begin
          i_r         <= '0;
          j_r         <= '0;
          key_count_r <= '0;
          keyed_r     <= 1'b1;
        end
        default: begin
          keyed_r <= keyed_r;
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pre) begin
      pvld_q_r  <= pvld_r[praddr];
      paddr_q_r <= praddr;
    end
    if (cmd.capture) begin
      hold_byte_r <= in_byte_in;
      hold_last_r <= in_last;
      ovf_r       <= (in_kind == KIND_KEY) && key_full;
    end
    case (cmd.op)
      OP_D_RD_J: begin
        si_r <= perm_rd;
      end
      OP_D_WR_I: begin
        sj_r <= perm_rd;
      end
      OP_D_OUT: begin
        out_byte_r <= hold_byte_r ^ perm_rd;
        out_last_r <= hold_last_r;
        out_kr_r   <= keyed_r;
        out_ovf_r  <= 1'b0;
      end
      OP_K_OUT: begin
        out_byte_r <= '0;
        out_last_r <= hold_last_r;
        out_kr_r   <= keyed_r;
        out_ovf_r  <= ovf_r;
      end
      OP_S_START: begin
        acc_r  <= '0;
        c_r    <= '0;
        k_r    <= '0;
        kmax_r <= (key_count_r == '0) ? '0 : kc_m1[KaW-1:0];
      end
      OP_S_RD_A: begin
        sc_r  <= perm_rd;
        acc_r <= acc_r + krdata + perm_rd;
      end
      OP_S_WR_A: begin
        c_r <= c_r + 8'd1;
        k_r <= (k_r == kmax_r) ? '0 : k_r + KaW'(1);
      end
      OP_S_DONE: begin
        out_byte_r <= '0;
        out_last_r <= hold_last_r;
        out_kr_r   <= 1'b1;
        out_ovf_r  <= ovf_r;
      end
      default: begin
        sc_r <= sc_r;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = out_byte_r;
  assign out_last_out     = out_last_r;
  assign out_key_ready    = out_kr_r;
  assign out_key_overflow = out_ovf_r;

endmodule

`default_nettype wire
